// ----- rtl/ccs_pkg.sv -----
// ----------------------------------------------------------------------------
// ccs_pkg: shared types, constants and tables for the contour cell block
// Holds the payload structs, the sign-case table and the segment case codes.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned VB           = 32;

  typedef struct packed {
    logic signed [VB-1:0] value_low_left;
    logic signed [VB-1:0] value_low_right;
    logic signed [VB-1:0] value_high_right;
    logic signed [VB-1:0] value_high_left;
    logic signed [VB-1:0] x_left;
    logic signed [VB-1:0] x_right;
    logic signed [VB-1:0] y_bottom;
    logic signed [VB-1:0] y_top;
  } cell_in_t;

  typedef struct packed {
    logic signed [VB-1:0] start_x;
    logic signed [VB-1:0] start_y;
    logic signed [VB-1:0] end_x;
    logic signed [VB-1:0] end_y;
    logic [1:0]           triangle_index;
    logic                 last_segment;
  } seg_out_t;

  typedef enum logic [3:0] {
    SegNone  = 4'd0,
    SegAB    = 4'd1,
    SegBC    = 4'd2,
    SegCA    = 4'd3,
    SegAxBC  = 4'd4,
    SegBxCA  = 4'd5,
    SegCxAB  = 4'd6,
    SegXabBc = 4'd7,
    SegXbcCa = 4'd8,
    SegXcaAb = 4'd9
  } seg_case_e;

  // sign codes: 0 negative, 1 zero, 2 positive
  function automatic seg_case_e seg_case_lookup(input logic [1:0] sa, input logic [1:0] sb,
                                                input logic [1:0] sc);
    logic [5:0] key;
    seg_case_e  r;
    key = {sa, sb, sc};
    case (key)
      6'b00_00_10: r = SegXbcCa;
      6'b00_01_01: r = SegBC;
      6'b00_01_10: r = SegBxCA;
      6'b00_10_00: r = SegXabBc;
      6'b00_10_01: r = SegCxAB;
      6'b00_10_10: r = SegXcaAb;
      6'b01_00_01: r = SegCA;
      6'b01_00_10: r = SegAxBC;
      6'b01_01_00: r = SegAB;
      6'b01_01_01: r = SegCA;
      6'b01_01_10: r = SegAB;
      6'b01_10_00: r = SegAxBC;
      6'b01_10_01: r = SegCA;
      6'b10_00_00: r = SegXcaAb;
      6'b10_00_01: r = SegCxAB;
      6'b10_00_10: r = SegXabBc;
      6'b10_01_00: r = SegBxCA;
      6'b10_01_01: r = SegBC;
      6'b10_10_00: r = SegXbcCa;
      default:     r = SegNone;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ccs_div.sv -----
// ----------------------------------------------------------------------------
// ccs_div: pipelined signed divider, truncating toward zero
// One restoring quotient bit per stage; the tag travels with each stage.
// ----------------------------------------------------------------------------
module ccs_div import ccs_pkg::*; #(
  parameter int unsigned NumBits = 72,
  parameter int unsigned DenBits = 40,
  parameter int unsigned QBits   = 36,
  parameter int unsigned TagBits = 8
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [NumBits-1:0] num_i,
  input  logic signed [DenBits-1:0] den_i,
  input  logic [TagBits-1:0]        tag_i,
  output logic signed [QBits-1:0]   quo_o,
  output logic [TagBits-1:0]        tag_o
);

  localparam int unsigned Steps = QBits;

  logic [NumBits-1:0] rem_q [Steps+1];
  logic [DenBits-1:0] den_q [Steps+1];
  logic [QBits-1:0]   quo_q [Steps+1];
  logic               neg_q [Steps+1];
  logic [TagBits-1:0] tag_q [Steps+1];

  logic [NumBits-1:0] num_mag;
  logic [DenBits-1:0] den_mag;

  assign num_mag = num_i[NumBits-1] ? NumBits'(-num_i) : num_i;
  assign den_mag = den_i[DenBits-1] ? DenBits'(-den_i) : den_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_mag;
      den_q[0] <= den_mag;
      quo_q[0] <= '0;
      neg_q[0] <= num_i[NumBits-1] ^ den_i[DenBits-1];
      tag_q[0] <= tag_i;
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int unsigned Sh = Steps - 1 - s;
    logic [NumBits+Steps-1:0] dsh;
    logic                     ge;
    assign dsh = (NumBits+Steps)'(den_q[s]) << Sh;
    assign ge  = (NumBits+Steps)'(rem_q[s]) >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? NumBits'((NumBits+Steps)'(rem_q[s]) - dsh) : rem_q[s];
        quo_q[s+1] <= {quo_q[s][QBits-2:0], ge};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign quo_o = neg_q[Steps] ? QBits'(-quo_q[Steps]) : quo_q[Steps];
  assign tag_o = tag_q[Steps];

endmodule

// ----- rtl/ccs_front.sv -----
// ----------------------------------------------------------------------------
// ccs_front: level compare, heights, signs and per-triangle segment setup
// Four register stages; produces dividend/divisor pairs for four triangles.
// ----------------------------------------------------------------------------
module ccs_front import ccs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  cell_in_t                    cell_i,
  input  logic signed [VB-1:0]        level_i,
  output logic                        valid_o,
  output logic [3:0]                  emit_o,
  output logic signed [2*VB+7:0]      num_o [4][4],
  output logic signed [VB+4:0]        den_o [4][4],
  output logic [3:0]                  direct_o [4]
);

  localparam int unsigned HB = VB + 5;  // scaled heights
  localparam int unsigned CB = VB + 2;  // scaled coordinates
  localparam int unsigned NB = 2*VB + 8;

  // stage 1: differences and range
  logic              v1_q;
  logic signed [VB:0] d1_q [4];
  cell_in_t          c1_q;
  logic              inr1_q;

  logic signed [VB-1:0] dv [4];
  assign dv[0] = cell_i.value_low_left;
  assign dv[1] = cell_i.value_low_right;
  assign dv[2] = cell_i.value_high_right;
  assign dv[3] = cell_i.value_high_left;

  logic any_le, any_ge;
  always_comb begin
    any_le = 1'b0;
    any_ge = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (dv[k] <= level_i) any_le = 1'b1;
      if (dv[k] >= level_i) any_ge = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) d1_q[k] <= (VB+1)'(dv[k]) - (VB+1)'(level_i);
      c1_q   <= cell_i;
      inr1_q <= any_le && any_ge;
    end
  end

  // stage 2: heights and coordinates
  logic                v2_q;
  logic signed [HB-1:0] h2_q [5];
  logic signed [CB-1:0] cx2_q [5];
  logic signed [CB-1:0] cy2_q [5];
  logic                inr2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h2_q[0] <= HB'(d1_q[0]) + HB'(d1_q[1]) + HB'(d1_q[2]) + HB'(d1_q[3]);
      for (int k = 0; k < 4; k++) h2_q[k+1] <= HB'(d1_q[k]) <<< 2;
      cx2_q[0] <= CB'(c1_q.x_left) + CB'(c1_q.x_right);
      cy2_q[0] <= CB'(c1_q.y_bottom) + CB'(c1_q.y_top);
      cx2_q[1] <= CB'(c1_q.x_left) <<< 1;
      cx2_q[2] <= CB'(c1_q.x_right) <<< 1;
      cx2_q[3] <= CB'(c1_q.x_right) <<< 1;
      cx2_q[4] <= CB'(c1_q.x_left) <<< 1;
      cy2_q[1] <= CB'(c1_q.y_bottom) <<< 1;
      cy2_q[2] <= CB'(c1_q.y_bottom) <<< 1;
      cy2_q[3] <= CB'(c1_q.y_top) <<< 1;
      cy2_q[4] <= CB'(c1_q.y_top) <<< 1;
      inr2_q <= inr1_q;
    end
  end

  function automatic logic [1:0] sgn(input logic signed [HB-1:0] h);
    return (h == '0) ? 2'd1 : (h[HB-1] ? 2'd0 : 2'd2);
  endfunction

  // stage 3: case select and operand setup per triangle
  // point slots: 0 start x, 1 start y, 2 end x, 3 end y
  logic                 v3_q;
  logic [3:0]           emit3_q;
  logic signed [HB-1:0] h1s [4][4];
  logic signed [HB-1:0] h2s [4][4];
  logic signed [CB-1:0] c1s [4][4];
  logic signed [CB-1:0] c2s [4][4];
  logic [3:0]           dir [4];
  logic [3:0]           emit;

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      int unsigned a, b, c, p, q, r, s;
      logic v1, v2;
      seg_case_e cs;
      a = t + 1; b = 0; c = (t == 3) ? 1 : t + 2;
      p = 0; q = 0; r = 0; s = 0; v1 = 1'b0; v2 = 1'b0;
      cs = seg_case_lookup(sgn(h2_q[a]), sgn(h2_q[b]), sgn(h2_q[c]));
      emit[t] = (cs != SegNone) && inr2_q;
      case (cs)
        SegAB:    begin p = a; q = b; v1 = 1'b1; v2 = 1'b1; end
        SegBC:    begin p = b; q = c; v1 = 1'b1; v2 = 1'b1; end
        SegCA:    begin p = c; q = a; v1 = 1'b1; v2 = 1'b1; end
        SegAxBC:  begin p = a; v1 = 1'b1; r = b; s = c; end
        SegBxCA:  begin p = b; v1 = 1'b1; r = c; s = a; end
        SegCxAB:  begin p = c; v1 = 1'b1; r = a; s = b; end
        SegXabBc: begin p = a; q = b; r = b; s = c; end
        SegXbcCa: begin p = b; q = c; r = c; s = a; end
        SegXcaAb: begin p = c; q = a; r = a; s = b; end
        default:  ;
      endcase
      // direct point: dividend = 2*c, divisor = 4 gives c/2 truncated
      dir[t] = {v2, v2, v1, v1};
      for (int k = 0; k < 4; k++) begin
        int unsigned i1, i2;
        logic dr;
        dr = (k < 2) ? v1 : v2;
        i1 = (k < 2) ? p : (v2 ? q : r);
        i2 = (k < 2) ? q : s;
        h1s[t][k] = h2_q[i1];
        h2s[t][k] = dr ? HB'(0) : h2_q[i2];
        c1s[t][k] = (k % 2 == 0) ? cx2_q[i1] : cy2_q[i1];
        c2s[t][k] = (k % 2 == 0) ? cx2_q[i2] : cy2_q[i2];
      end
    end
  end

  // products registered here, subtracted next stage
  logic signed [NB-1:0] pa_q [4][4];
  logic signed [NB-1:0] pb_q [4][4];
  logic signed [HB:0]   dn_q [4][4];
  logic signed [CB-1:0] cd_q [4][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en_i) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      emit3_q <= emit;
      for (int t = 0; t < 4; t++) begin
        direct_o[t] <= dir[t];
        for (int k = 0; k < 4; k++) begin
          pa_q[t][k] <= NB'(h2s[t][k]) * NB'(c1s[t][k]);
          pb_q[t][k] <= NB'(h1s[t][k]) * NB'(c2s[t][k]);
          dn_q[t][k] <= (HB+1)'(h2s[t][k]) - (HB+1)'(h1s[t][k]);
          cd_q[t][k] <= c1s[t][k];
        end
      end
    end
  end

  // stage 4: dividend and divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      emit_o <= emit3_q;
      for (int t = 0; t < 4; t++) begin
        for (int k = 0; k < 4; k++) begin
          if (direct_o[t][k]) begin
            num_o[t][k] <= NB'(cd_q[t][k]) <<< 1;
            den_o[t][k] <= (HB)'(4);
          end else begin
            num_o[t][k] <= pa_q[t][k] - pb_q[t][k];
            den_o[t][k] <= HB'(dn_q[t][k]) <<< 1;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/ccs_serial.sv -----
// ----------------------------------------------------------------------------
// ccs_serial: result queue that emits one segment per cycle while not stalled
// Holds one cell of up to four segments; stalls the pipeline when full.
// ----------------------------------------------------------------------------
module ccs_serial import ccs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  logic [3:0] emit_i,
  input  logic signed [VB-1:0] pts_i [4][4],
  output logic     full_o,
  output logic     valid_o,
  output seg_out_t seg_o,
  input  logic     stall_i
);

  logic [3:0]           pend_q, pend_d;
  logic signed [VB-1:0] pts_q [4][4];
  logic [1:0]           sel;
  logic [3:0]           rest;

  always_comb begin
    sel = 2'd0;
    for (int t = 3; t >= 0; t--) if (pend_q[t]) sel = 2'(t);
    rest = pend_q & ~(4'b1 << sel);
  end

  assign valid_o = pend_q != '0;
  assign full_o  = (pend_q != '0) && !((rest == '0) && !stall_i);
  assign seg_o.start_x        = pts_q[sel][0];
  assign seg_o.start_y        = pts_q[sel][1];
  assign seg_o.end_x          = pts_q[sel][2];
  assign seg_o.end_y          = pts_q[sel][3];
  assign seg_o.triangle_index = sel;
  assign seg_o.last_segment   = rest == '0;

  always_comb begin
    pend_d = pend_q;
    if (valid_o && !stall_i) pend_d = rest;
    if (valid_i && !full_o) pend_d = emit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else pend_q <= pend_d;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !full_o) pts_q <= pts_i;
  end

endmodule

// ----- rtl/contour_cell_segments.sv -----
// ----------------------------------------------------------------------------
// contour_cell_segments: contour segments of one grid cell at one level
// Top level with the configuration port, pipeline and output queue.
// ----------------------------------------------------------------------------
// A cell item enters when no stall is held; up to four segment items follow,
// one per cycle while out_stall_i is low, the last marked. The path runs
// through four setup stages, 37 pipelined divider stages (an input register
// and 36 quotient steps) that produce all sixteen coordinates of a cell at
// once, and the output queue. A cell holds the queue until its last segment
// is taken, and the next cell may enter as that segment leaves.
module contour_cell_segments import ccs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  cell_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output seg_out_t    out_data_o
);

  localparam int unsigned NB = 2*VB + 8;
  localparam int unsigned DB = VB + 5;
  localparam int unsigned QB = VB + 4;
  localparam int unsigned Depth = QB + 1;

  logic signed [VB-1:0] level_q;
  logic                 en;
  logic                 full;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? level_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) level_q <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) level_q <= pwdata;
  end

  assign en         = !full;
  assign in_stall_o = full;

  logic                 fv;
  logic [3:0]           femit;
  logic signed [NB-1:0] num [4][4];
  logic signed [DB-1:0] den [4][4];
  logic [3:0]           fdir [4];

  ccs_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .cell_i(in_data_i),
    .level_i(level_q), .valid_o(fv), .emit_o(femit), .num_o(num), .den_o(den),
    .direct_o(fdir)
  );

  logic signed [QB-1:0] quo [4][4];
  logic [4:0]           tg [4][4];
  logic signed [VB-1:0] pts [4][4];

  for (genvar t = 0; t < 4; t++) begin : g_t
    for (genvar k = 0; k < 4; k++) begin : g_k
      ccs_div #(.NumBits(NB), .DenBits(DB), .QBits(QB), .TagBits(5)) u_div (
        .clk_i, .en_i(en), .num_i(num[t][k]), .den_i(den[t][k]),
        .tag_i({fv, femit}), .quo_o(quo[t][k]), .tag_o(tg[t][k])
      );
      assign pts[t][k] = quo[t][k][VB-1:0];
    end
  end

  // valid through divider stages is reset-cleared separately
  logic [Depth-1:0] dv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else if (en) dv_q <= {dv_q[Depth-2:0], fv};
  end

  ccs_serial u_serial (
    .clk_i, .rst_ni, .valid_i(dv_q[Depth-1] && tg[0][0][4] && tg[0][0][3:0] != '0),
    .emit_i(tg[0][0][3:0]), .pts_i(pts), .full_o(full), .valid_o(out_valid_o),
    .seg_o(out_data_o), .stall_i(out_stall_i)
  );

endmodule
